@@ rtl/csvt_pkg.sv @@
package csvt_pkg;

  // Widest record the tokenizer numbers; field numbers are 5 bits wide.
  localparam int MaxFields  = 32;
  localparam int FieldLimit = (MaxFields < 32) ? MaxFields : 32;
  localparam int FieldCap   = FieldLimit - 1;

  localparam logic [7:0] QuoteCh   = 8'h22;
  localparam logic [7:0] NewlineCh = 8'h0A;
  localparam logic [7:0] CommaCh   = 8'h2C;

  // Command queue between front and back
  localparam int CmdqDepth = 4;
  localparam int CmdqAw    = $clog2(CmdqDepth);

  // Result buffer in front of the output ports
  localparam int OutqDepth = 2;
  localparam int OutqAw    = $clog2(OutqDepth);

  typedef enum logic [1:0] {
    REG_DELIM  = 2'd0,
    REG_QMODE  = 2'd1,
    REG_RECF   = 2'd2,
    REG_UNUSED = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    QM_NONE = 2'd0,
    QM_WEAK = 2'd1,
    QM_RFC  = 2'd2,
    QM_RFC3 = 2'd3
  } qmode_e;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_FIELD  = 2'd1,
    KIND_RECORD = 2'd2,
    KIND_QERR   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    SC_START  = 3'd0,
    SC_PLAIN  = 3'd1,
    SC_RQ     = 3'd2,
    SC_RQSEEN = 3'd3,
    SC_WQ     = 3'd4,
    SC_WQSEEN = 3'd5
  } scan_e;

  typedef enum logic [2:0] {
    OP_DATA       = 3'd0,
    OP_ERR_DATA   = 3'd1,
    OP_QUOTE_DATA = 3'd2,
    OP_FIELD      = 3'd3,
    OP_RECORD     = 3'd4,
    OP_RECORD_ERR = 3'd5
  } op_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [4:0] field_number;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] delim;
    qmode_e     qmode;
    logic [5:0] rec_fields;
  } cfg_t;

  // One command per accepted beat that produces results
  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic [4:0] field;
    logic [5:0] target;
  } cmd_t;

endpackage

@@ rtl/csvt_front.sv @@
module csvt_front import csvt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  in_item_t in_item_i,
  input  logic     accept_i,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o
);

  scan_e      scan_q, scan_d;
  logic [4:0] count_q, count_d;
  logic       open_q, open_d;

  logic [7:0] b;
  logic       eos, is_quote, is_nl, is_delim, quoting;
  logic [4:0] count_inc;
  logic [5:0] target;

  assign b        = in_item_i.in_byte;
  assign eos      = in_item_i.end_of_stream;
  assign is_quote = (b == QuoteCh);
  assign is_nl    = (b == NewlineCh);
  assign is_delim = (b == cfg_i.delim);
  assign quoting  = (cfg_i.qmode != QM_NONE);

  // Saturate at the last field number
  assign count_inc = (count_q < 5'(FieldCap)) ? count_q + 5'd1 : count_q;
  assign target    = (cfg_i.rec_fields > 6'(FieldLimit)) ? 6'(FieldLimit)
                                                         : cfg_i.rec_fields;

  // Next state
  always_comb begin
    scan_d  = scan_q;
    count_d = count_q;
    open_d  = open_q;
    if (accept_i) begin
      if (eos) begin
        scan_d  = SC_START;
        count_d = '0;
        open_d  = 1'b0;
      end else begin
        unique case (scan_q)
          SC_START: begin
            if (quoting && is_quote) begin
              open_d = 1'b1;
              scan_d = (cfg_i.qmode == QM_WEAK) ? SC_WQ : SC_RQ;
            end else if (is_nl) begin
              count_d = '0;
              open_d  = 1'b0;
            end else if (is_delim) begin
              count_d = count_inc;
              open_d  = 1'b1;
            end else begin
              open_d = 1'b1;
              scan_d = SC_PLAIN;
            end
          end
          SC_PLAIN, SC_RQSEEN, SC_WQSEEN: begin
            if (scan_q == SC_RQSEEN && is_quote) begin
              scan_d = SC_RQ;
            end else if (is_nl) begin
              scan_d  = SC_START;
              count_d = '0;
              open_d  = 1'b0;
            end else if (is_delim) begin
              scan_d  = SC_START;
              count_d = count_inc;
              open_d  = 1'b1;
            end else if (scan_q == SC_RQSEEN) begin
              scan_d = SC_PLAIN;
            end else if (scan_q == SC_WQSEEN && !is_quote) begin
              scan_d = SC_WQ;
            end
          end
          SC_RQ: begin
            if (is_quote) scan_d = SC_RQSEEN;
          end
          SC_WQ: begin
            if (is_quote) scan_d = SC_WQSEEN;
          end
          default: scan_d = SC_START;
        endcase
      end
    end
  end

  // Command to the back part
  always_comb begin
    cmd_valid_o   = 1'b0;
    cmd_o.op      = OP_DATA;
    cmd_o.data    = b;
    cmd_o.field   = count_q;
    cmd_o.target  = target;
    if (eos) begin
      if (scan_q == SC_RQ || scan_q == SC_WQ) begin
        cmd_valid_o = 1'b1;
        cmd_o.op    = OP_RECORD_ERR;
      end else if (scan_q != SC_START || open_q) begin
        cmd_valid_o = 1'b1;
        cmd_o.op    = OP_RECORD;
      end
    end else begin
      unique case (scan_q)
        SC_START, SC_PLAIN: begin
          if (!(scan_q == SC_START && quoting && is_quote)) begin
            cmd_valid_o = 1'b1;
            if (is_nl)         cmd_o.op = OP_RECORD;
            else if (is_delim) cmd_o.op = OP_FIELD;
            else               cmd_o.op = OP_DATA;
          end
        end
        SC_RQ, SC_WQ: begin
          cmd_valid_o = !is_quote;
          cmd_o.op    = OP_DATA;
        end
        SC_RQSEEN: begin
          cmd_valid_o = 1'b1;
          if (is_quote) begin
            cmd_o.op   = OP_DATA;
            cmd_o.data = QuoteCh;
          end else if (is_nl) begin
            cmd_o.op = OP_RECORD;
          end else if (is_delim) begin
            cmd_o.op = OP_FIELD;
          end else begin
            cmd_o.op = OP_ERR_DATA;
          end
        end
        SC_WQSEEN: begin
          cmd_valid_o = 1'b1;
          if (is_nl) begin
            cmd_o.op = OP_RECORD;
          end else if (is_delim) begin
            cmd_o.op = OP_FIELD;
          end else if (is_quote) begin
            cmd_o.op   = OP_DATA;
            cmd_o.data = QuoteCh;
          end else begin
            cmd_o.op = OP_QUOTE_DATA;
          end
        end
        default: cmd_valid_o = 1'b0;
      endcase
    end
    cmd_valid_o = cmd_valid_o & accept_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= SC_START;
      count_q <= '0;
      open_q  <= 1'b0;
    end else begin
      scan_q  <= scan_d;
      count_q <= count_d;
      open_q  <= open_d;
    end
  end

`ifndef SYNTHESIS
  a_eos_resets : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && eos |=> scan_q == SC_START && count_q == '0 && !open_q)
    else $error("end of stream did not return scanner to field start");

  a_field_start_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> count_q == '0 && (scan_q == SC_START))
    else $error("closed record holds a field count or scan state");

  a_quote_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !eos && is_quote && (scan_q == SC_RQ || scan_q == SC_WQ)
      |-> !cmd_valid_o)
    else $error("closing quote produced a command");
`endif

endmodule

@@ rtl/csvt_cmd_queue.sv @@
module csvt_cmd_queue import csvt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  cmd_t              mem_q [CmdqDepth];
  logic [CmdqAw-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CmdqAw:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (CmdqAw+1)'(CmdqDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == CmdqAw'(CmdqDepth - 1)) ? '0 : wr_q + CmdqAw'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == CmdqAw'(CmdqDepth - 1)) ? '0 : rd_q + CmdqAw'(1);
    end
    if (do_push && !do_pop) cnt_d = cnt_q + (CmdqAw+1)'(1);
    else if (!do_push && do_pop) cnt_d = cnt_q - (CmdqAw+1)'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command pushed into a full queue");

  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("command popped from an empty queue");

  a_ptr_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == (CmdqAw+1)'(CmdqDepth)) |-> wr_q == rd_q)
    else $error("queue pointers disagree with fill count");
`endif

endmodule

@@ rtl/csvt_back.sv @@
module csvt_back import csvt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t out_item_o
);

  logic              phase_q, phase_d;
  logic [5:0]        cur_q, cur_d;
  logic [5:0]        f_now, f_next;
  logic              more_pad, final_res, fire, is_rec;
  out_item_t         res;

  out_item_t         oq_q [OutqDepth];
  logic [OutqAw-1:0] owr_q, ord_q;
  logic [OutqAw:0]   ocnt_q;
  logic              oq_ready, oq_pop;

  assign f_now    = phase_q ? cur_q : {1'b0, cmd_i.field};
  assign f_next   = f_now + 6'd1;
  assign more_pad = (f_next < cmd_i.target);
  assign is_rec   = (cmd_i.op == OP_RECORD || cmd_i.op == OP_RECORD_ERR);

  // Decode the head command into the current result beat
  always_comb begin
    res.kind         = KIND_DATA;
    res.out_byte     = '0;
    res.field_number = f_now[4:0];
    final_res        = 1'b1;
    unique case (cmd_i.op)
      OP_DATA: begin
        res.out_byte = cmd_i.data;
      end
      OP_ERR_DATA: begin
        if (!phase_q) begin
          res.kind  = KIND_QERR;
          final_res = 1'b0;
        end else begin
          res.out_byte = cmd_i.data;
        end
      end
      OP_QUOTE_DATA: begin
        res.out_byte = phase_q ? cmd_i.data : QuoteCh;
        final_res    = phase_q;
      end
      OP_FIELD: begin
        res.kind = KIND_FIELD;
      end
      OP_RECORD, OP_RECORD_ERR: begin
        if (cmd_i.op == OP_RECORD_ERR && !phase_q) res.kind = KIND_QERR;
        else if (more_pad)                         res.kind = KIND_FIELD;
        else                                       res.kind = KIND_RECORD;
        final_res = !more_pad;
      end
      default: res.kind = KIND_DATA;
    endcase
    res.last = final_res;
  end

  assign oq_ready  = (ocnt_q != (OutqAw+1)'(OutqDepth));
  assign fire      = cmd_valid_i && oq_ready;
  assign cmd_pop_o = fire && final_res;

  // Advance the field number only across pad beats; two-beat data stays in its field
  always_comb begin
    phase_d = phase_q;
    cur_d   = cur_q;
    if (fire) begin
      phase_d = !final_res;
      cur_d   = is_rec ? f_next : f_now;
    end
  end

  // Result buffer: takes a beat while the previous one waits at the ports
  assign empty_o    = (ocnt_q == '0);
  assign out_item_o = oq_q[ord_q];
  assign oq_pop     = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (fire) oq_q[owr_q] <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      cur_q   <= '0;
      owr_q   <= '0;
      ord_q   <= '0;
      ocnt_q  <= '0;
    end else begin
      phase_q <= phase_d;
      cur_q   <= cur_d;
      if (fire) begin
        owr_q <= (owr_q == OutqAw'(OutqDepth - 1)) ? '0 : owr_q + OutqAw'(1);
      end
      if (oq_pop) begin
        ord_q <= (ord_q == OutqAw'(OutqDepth - 1)) ? '0 : ord_q + OutqAw'(1);
      end
      if (fire && !oq_pop)      ocnt_q <= ocnt_q + (OutqAw+1)'(1);
      else if (!fire && oq_pop) ocnt_q <= ocnt_q - (OutqAw+1)'(1);
    end
  end

`ifndef SYNTHESIS
  a_mid_cmd_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> cmd_valid_i)
    else $error("command left the queue before its last beat");

  a_mid_cmd_op : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (cmd_i.op == OP_ERR_DATA || cmd_i.op == OP_QUOTE_DATA ||
                 cmd_i.op == OP_RECORD || cmd_i.op == OP_RECORD_ERR))
    else $error("single beat command in a later phase");

  a_pad_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !final_res && is_rec |=> f_now == $past(f_next))
    else $error("pad field number skipped");

  a_oq_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= (OutqAw+1)'(OutqDepth))
    else $error("result buffer overfilled");
`endif

endmodule

@@ rtl/csv_field_tokenizer.sv @@
// Channel   Dir  Handshake               Payload
// input     in   push / full             in_item_i  (in_byte, end_of_stream)
// result    out  pop / empty             out_item_o (kind, out_byte, field_number, last)
// config    in   cfg_we_i, cfg_idx_i     cfg_data_i (delimiter, quote_mode, record_fields)
//
// One input beat per cycle while each beat yields at most one result and results are popped.
// A beat that yields k results occupies the back end until all k are out (two for a
// stray or weak quote, up to record_fields for a padded record end); the
// four-entry command queue absorbs this and full rises only when it fills.
// Beats that yield no result (quotes that open or close a field) push no command.
// Reset clears scanner state, both queues and loads comma, RFC4180, no padding.
// A stalled result port holds the result buffer; the input keeps flowing
// until the command queue fills.
module csv_field_tokenizer import csvt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  cfg_t cfg_q;
  logic accept, cmd_push, cmd_valid, cmd_pop;
  cmd_t cmd_in, cmd_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delim      <= CommaCh;
      cfg_q.qmode      <= QM_RFC;
      cfg_q.rec_fields <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DELIM: cfg_q.delim      <= cfg_data_i;
        REG_QMODE: cfg_q.qmode      <= qmode_e'(cfg_data_i[1:0]);
        REG_RECF:  cfg_q.rec_fields <= cfg_data_i[5:0];
        default:   cfg_q.delim      <= cfg_q.delim;
      endcase
    end
  end

  assign accept = push && !full;

  csvt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_item_i   (in_item_i),
    .accept_i    (accept),
    .cmd_valid_o (cmd_push),
    .cmd_o       (cmd_in)
  );

  csvt_cmd_queue u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_head)
  );

  csvt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_item_o  (out_item_o)
  );

endmodule

@@ tb/sv/csvt_checker.sv @@
`timescale 1ns / 100ps

module csvt_checker import csvt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  in_item_t    in_item_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  out_item_t   out_item_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  logic [7:0] delim;
  qmode_e     qmode;
  logic [5:0] pad_fields;
  scan_e      scan;
  logic [4:0] field_idx;
  logic       rec_open;

  out_item_t beat_tokens[$];
  out_item_t expected_tokens[$];

  function automatic void add_token(kind_e k, logic [7:0] b, logic [4:0] f);
    out_item_t t;
    if (beat_tokens.size() >= 32) return;
    t.kind         = k;
    t.out_byte     = b;
    t.field_number = f;
    t.last         = 1'b0;
    beat_tokens.push_back(t);
  endfunction

  function automatic void end_field();
    add_token(KIND_FIELD, 8'h00, field_idx);
    if (field_idx < FieldCap) field_idx = field_idx + 5'd1;
    rec_open = 1'b1;
    scan     = SC_START;
  endfunction

  // Close the record, then pad with empty fields; the final pad closes it.
  function automatic void end_record(bit as_error);
    int target;
    int fc;
    target = pad_fields;
    if (target > FieldLimit) target = FieldLimit;
    fc = field_idx;
    if (as_error) add_token(KIND_QERR, 8'h00, field_idx);
    else add_token((fc + 1 < target) ? KIND_FIELD : KIND_RECORD, 8'h00, field_idx);
    for (int f = fc + 1; f < target; f++)
      add_token((f + 1 < target) ? KIND_FIELD : KIND_RECORD, 8'h00, f[4:0]);
    field_idx = '0;
    rec_open  = 1'b0;
    scan      = SC_START;
  endfunction

  function automatic void tokenize_beat(in_item_t it);
    logic [7:0] b;
    b = it.in_byte;
    beat_tokens.delete();
    if (it.end_of_stream) begin
      if (scan == SC_RQ || scan == SC_WQ) end_record(1'b1);
      else if (scan != SC_START || rec_open) end_record(1'b0);
      scan      = SC_START;
      field_idx = '0;
      rec_open  = 1'b0;
    end else begin
      case (scan)
        SC_START: begin
          // an opening quote wins over newline and delimiter
          if (qmode != QM_NONE && b == QuoteCh) begin
            rec_open = 1'b1;
            scan     = (qmode == QM_WEAK) ? SC_WQ : SC_RQ;
          end else if (b == NewlineCh) begin
            end_record(1'b0);
          end else if (b == delim) begin
            end_field();
          end else begin
            rec_open = 1'b1;
            add_token(KIND_DATA, b, field_idx);
            scan = SC_PLAIN;
          end
        end
        SC_PLAIN: begin
          if (b == NewlineCh) end_record(1'b0);
          else if (b == delim) end_field();
          else add_token(KIND_DATA, b, field_idx);
        end
        SC_RQ: begin
          if (b == QuoteCh) scan = SC_RQSEEN;
          else add_token(KIND_DATA, b, field_idx);
        end
        SC_RQSEEN: begin
          if (b == QuoteCh) begin
            add_token(KIND_DATA, QuoteCh, field_idx);
            scan = SC_RQ;
          end else if (b == NewlineCh) begin
            end_record(1'b0);
          end else if (b == delim) begin
            end_field();
          end else begin
            // stray byte after the closing quote: flag, then continue unquoted
            add_token(KIND_QERR, 8'h00, field_idx);
            add_token(KIND_DATA, b, field_idx);
            scan = SC_PLAIN;
          end
        end
        SC_WQ: begin
          if (b == QuoteCh) scan = SC_WQSEEN;
          else add_token(KIND_DATA, b, field_idx);
        end
        SC_WQSEEN: begin
          if (b == NewlineCh) begin
            end_record(1'b0);
          end else if (b == delim) begin
            end_field();
          end else if (b == QuoteCh) begin
            add_token(KIND_DATA, QuoteCh, field_idx);
          end else begin
            add_token(KIND_DATA, QuoteCh, field_idx);
            add_token(KIND_DATA, b, field_idx);
            scan = SC_WQ;
          end
        end
        default: scan = SC_START;
      endcase
    end
    foreach (beat_tokens[i]) begin
      beat_tokens[i].last = (i == beat_tokens.size() - 1);
      expected_tokens.push_back(beat_tokens[i]);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim        = CommaCh;
      qmode        = QM_RFC;
      pad_fields   = '0;
      scan         = SC_START;
      field_idx    = '0;
      rec_open     = 1'b0;
      expected_tokens.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (expected_tokens.size() == 0) begin
          $display("%0t: unexpected result kind %0d byte %02h field %0d last %0b", $time,
                   out_item_i.kind, out_item_i.out_byte, out_item_i.field_number,
                   out_item_i.last);
          fail_count_o = fail_count_o + 1;
        end else begin
          out_item_t exp_tok;
          exp_tok = expected_tokens.pop_front();
          if (out_item_i.kind !== exp_tok.kind || out_item_i.out_byte !== exp_tok.out_byte ||
              out_item_i.field_number !== exp_tok.field_number ||
              out_item_i.last !== exp_tok.last) begin
            $display({"%0t: mismatch: expected kind %0d byte %02h field %0d last %0b,",
                      " got kind %0d byte %02h field %0d last %0b"}, $time,
                     exp_tok.kind, exp_tok.out_byte, exp_tok.field_number, exp_tok.last,
                     out_item_i.kind, out_item_i.out_byte, out_item_i.field_number,
                     out_item_i.last);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_DELIM: delim      = cfg_data_i;
          REG_QMODE: qmode      = qmode_e'(cfg_data_i[1:0]);
          REG_RECF:  pad_fields = cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (push_i && !full_i) tokenize_beat(in_item_i);
      pending_o = expected_tokens.size();
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import csvt_pkg::*;

  logic       clk      = 1'b0;
  logic       rst_n    = 1'b0;
  logic       push     = 1'b0;
  logic       full;
  in_item_t   in_item  = '0;
  logic       empty;
  logic       pop      = 1'b0;
  out_item_t  out_item;
  logic       cfg_we   = 1'b0;
  logic [1:0] cfg_idx  = '0;
  logic [7:0] cfg_data = '0;

  int unsigned fail_count;
  int unsigned pending;

  int         send_idle  = 0;
  int         recv_stall = 0;
  logic [7:0] cur_delim  = CommaCh;
  in_item_t   stream[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  csv_field_tokenizer u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  csvt_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .push_i       (push),
    .full_i       (full),
    .in_item_i    (in_item),
    .empty_i      (empty),
    .pop_i        (pop),
    .out_item_i   (out_item),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk) pop <= rst_n && ($urandom_range(99) >= recv_stall);

  task automatic send_beat(in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      push    <= 1'b0;
      in_item <= in_item_t'($urandom_range(511));
      @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Hold off until every expected result is out, then let the back end settle.
  task automatic drain();
    push <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_config(logic [7:0] d, qmode_e q, logic [5:0] r);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_DELIM;
    cfg_data <= d;
    @(posedge clk);
    cfg_idx  <= REG_QMODE;
    cfg_data <= {6'b0, q};
    @(posedge clk);
    cfg_idx  <= REG_RECF;
    cfg_data <= {2'b0, r};
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_delim  = d;
  endtask

  task automatic queue_byte(logic [7:0] b);
    in_item_t it;
    it.in_byte       = b;
    it.end_of_stream = 1'b0;
    stream.push_back(it);
  endtask

  task automatic queue_eos();
    in_item_t it;
    it.in_byte       = 8'($urandom_range(255));
    it.end_of_stream = 1'b1;
    stream.push_back(it);
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == NewlineCh || b == QuoteCh || b == cur_delim);
    return b;
  endfunction

  task automatic add_field(bit short);
    if (short) begin
      if ($urandom_range(2) == 0) queue_byte(text_byte());
    end else begin
      case ($urandom_range(9))
        0, 1, 2, 3: repeat ($urandom_range(6)) queue_byte(text_byte());
        4, 5: begin
          queue_byte(QuoteCh);
          repeat ($urandom_range(5)) begin
            case ($urandom_range(5))
              0: begin
                queue_byte(QuoteCh);
                queue_byte(QuoteCh);
              end
              1: queue_byte(NewlineCh);
              2: queue_byte(cur_delim);
              default: queue_byte(text_byte());
            endcase
          end
          queue_byte(QuoteCh);
          if ($urandom_range(4) == 0) queue_byte(text_byte());
        end
        6, 7: begin
          queue_byte(QuoteCh);
          repeat ($urandom_range(5)) begin
            case ($urandom_range(4))
              0: begin
                queue_byte(QuoteCh);
                queue_byte(text_byte());
              end
              1: queue_byte(NewlineCh);
              2: queue_byte(cur_delim);
              3: begin
                queue_byte(QuoteCh);
                queue_byte(QuoteCh);
                queue_byte(text_byte());
              end
              default: queue_byte(text_byte());
            endcase
          end
          queue_byte(QuoteCh);
        end
        8: repeat ($urandom_range(4, 1)) queue_byte(8'($urandom_range(255)));
        default: ;
      endcase
    end
  endtask

  task automatic add_record(bit force_long);
    int nf;
    nf = (force_long || $urandom_range(14) == 0) ? $urandom_range(40, 33)
                                                 : $urandom_range(5, 1);
    for (int k = 0; k < nf; k++) begin
      if (k > 0) queue_byte(cur_delim);
      add_field(nf > 8);
    end
    case ($urandom_range(15))
      0: queue_eos();
      1: begin
        queue_byte(QuoteCh);
        queue_byte(text_byte());
        queue_eos();
      end
      default: queue_byte(NewlineCh);
    endcase
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // quoted newline, doubled quote, stray byte, empty line, extremes
    queue_text("a,\"\n\"\"\"x\n\n");
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(QuoteCh);
    queue_eos();
    queue_byte(QuoteCh);
    queue_eos();
    queue_eos();
    queue_byte(CommaCh);
    queue_eos();
    foreach (stream[i]) send_beat(stream[i]);
    stream.delete();
    drain();

    // weak quoting with padding
    set_config(CommaCh, QM_WEAK, 6'd3);
    queue_text("\"a\"\"b\"\n");
    foreach (stream[i]) send_beat(stream[i]);
    stream.delete();

    for (int p = 0; p < 4; p++) begin
      drain();
      case (p)
        0: begin
          set_config(8'h00, QM_NONE, 6'd0);
          send_idle = 0;
          recv_stall <= 0;
        end
        1: begin
          set_config(CommaCh, QM_WEAK, 6'd32);
          send_idle = 78;
          recv_stall <= 0;
        end
        2: begin
          set_config(8'hFF, QM_RFC, 6'd5);
          send_idle = 0;
          recv_stall <= 78;
        end
        default: begin
          set_config(8'($urandom_range(255)), QM_RFC3, 6'd63);
          send_idle = 7;
          recv_stall <= 7;
        end
      endcase
      add_record(p == 0);
      while (stream.size() < 65) add_record(1'b0);
      // cut the phase mid-record so the next settings land inside a field
      for (int n = 0; n < 65; n++) begin
        send_beat(stream[n]);
        if (p == 1 && n == 32) drain();
      end
      stream.delete();
    end

    drain();
    if (fail_count == 0 && pending == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
